// File: src/qsf_pkg.sv
// shared types, widths and constants for the quaternion smoothing filter
// no dependencies; used by the interfaces and every module under src
package qsf_pkg;

  localparam int COMP_W = 16;
  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [COMP_W-1:0] word_t;

  // serial multiplier: 18 bit signed operands, 17 bit magnitudes
  localparam int MUL_IN_W  = 18;
  localparam int MUL_MAG_W = MUL_IN_W - 1;
  localparam int PROD_W    = 2 * MUL_IN_W;
  localparam int MUL_CNT_W = $clog2(MUL_MAG_W);
  typedef logic signed [MUL_IN_W-1:0] mul_in_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // squared magnitude of the rounded blend
  localparam int MAG2_W = 33;
  localparam logic [MAG2_W-1:0] MAG2_MIN = 33'd26844;
  localparam logic [MAG2_W-1:0] MAG2_MAX = 33'd2684354560;

  // square root of mag2 * 2^16
  localparam int RAD_W      = 50;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_CNT_W = $clog2(ROOT_W);

  // divider for the normalised components
  localparam int NUM_W     = 38;
  localparam int DEN_W     = ROOT_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int NORM_SHIFT = 22;

  localparam comp_t Q_ONE   = 16'sd16384;
  localparam comp_t Q_MAX   = 16'sd32767;
  localparam comp_t Q_MIN   = -16'sd32768;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND  = 2'd0,
    REG_FAST   = 2'd1,
    REG_DEAD   = 2'd2,
    REG_MOTION = 2'd3
  } cfg_reg_t;

  localparam word_t BLEND_RST  = 16'd39322;
  localparam word_t FAST_RST   = 16'd49152;
  localparam word_t DEAD_RST   = 16'd49;
  localparam word_t MOTION_RST = 16'd8192;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DOT, S_DOT_W, S_FLIP,
    S_DIST, S_DIST_W,
    S_DB, S_DB_W, S_ML, S_ML_W,
    S_BLA, S_BLA_W, S_BLB, S_BLB_W, S_RND,
    S_MAG, S_MAG_W, S_RANGE,
    S_SQRT, S_SQRT_W,
    S_DIV, S_DIV_W,
    S_DONE
  } state_t;

endpackage

// File: src/qsf_in_if.sv
// input channel of the smoothing filter: one quaternion and a restart flag
// depends on qsf_pkg
interface qsf_in_if;
  logic                 valid;
  logic                 ready;
  qsf_pkg::comp_t       in_w;
  qsf_pkg::comp_t       in_x;
  qsf_pkg::comp_t       in_y;
  qsf_pkg::comp_t       in_z;
  logic                 restart;
  modport source (output valid, in_w, in_x, in_y, in_z, restart, input ready);
  modport sink   (input valid, in_w, in_x, in_y, in_z, restart, output ready);
endinterface

// File: src/qsf_out_if.sv
// result channel of the smoothing filter: one smoothed quaternion
// depends on qsf_pkg
interface qsf_out_if;
  logic                 valid;
  logic                 ready;
  qsf_pkg::comp_t       out_w;
  qsf_pkg::comp_t       out_x;
  qsf_pkg::comp_t       out_y;
  qsf_pkg::comp_t       out_z;
  modport source (output valid, out_w, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_w, out_x, out_y, out_z, output ready);
endinterface

// File: src/qsf_cfg_if.sv
// configuration write channel: register index and write data
// depends on qsf_pkg
interface qsf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qsf_pkg::CFG_IDX_W-1:0]     index;
  qsf_pkg::word_t                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/qsf_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on qsf_pkg
module qsf_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  qsf_pkg::mul_in_t a,
  input  qsf_pkg::mul_in_t b,
  output logic             done,
  output qsf_pkg::prod_t   prod
);

  localparam int AW = 2 * qsf_pkg::MUL_MAG_W;

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [qsf_pkg::MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]                     mcand_r, mcand_nxt;
  logic [qsf_pkg::MUL_MAG_W-1:0]     mplier_r, mplier_nxt;
  logic [AW-1:0]                     acc_r, acc_nxt;
  logic                              neg_r, neg_nxt;
  qsf_pkg::mul_in_t                  abs_a, abs_b;

  always_comb begin
    abs_a = a[qsf_pkg::MUL_IN_W-1] ? -a : a;
    abs_b = b[qsf_pkg::MUL_IN_W-1] ? -b : b;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      mcand_nxt  = AW'(abs_a[qsf_pkg::MUL_MAG_W-1:0]);
      mplier_nxt = abs_b[qsf_pkg::MUL_MAG_W-1:0];
      acc_nxt    = '0;
      neg_nxt    = a[qsf_pkg::MUL_IN_W-1] ^ b[qsf_pkg::MUL_IN_W-1];
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[AW-2:0], 1'b0};
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == qsf_pkg::MUL_CNT_W'(qsf_pkg::MUL_MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r    <= cnt_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
  end

  assign done = done_r;
  assign prod = neg_r ? -qsf_pkg::prod_t'(acc_r) : qsf_pkg::prod_t'(acc_r);

endmodule

// File: src/qsf_sqrt.sv
// integer square root, one result bit (two radicand bits) per cycle
// depends on qsf_pkg
module qsf_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qsf_pkg::RAD_W-1:0]   rad,
  output logic                        done,
  output logic [qsf_pkg::ROOT_W-1:0]  root
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [qsf_pkg::SQRT_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [qsf_pkg::RAD_W-1:0]          rad_r, rad_nxt;
  logic [qsf_pkg::REM_W-1:0]          rem_r, rem_nxt;
  logic [qsf_pkg::ROOT_W-1:0]         root_r, root_nxt;
  logic [qsf_pkg::REM_W-1:0]          rem2, trial;
  logic                               ge;

  always_comb begin
    rem2  = {rem_r[qsf_pkg::REM_W-3:0], rad_r[qsf_pkg::RAD_W-1 -: 2]};
    trial = qsf_pkg::REM_W'({root_r, 2'b01});
    ge    = rem2 >= trial;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem2 - trial : rem2;
      root_nxt = {root_r[qsf_pkg::ROOT_W-2:0], ge};
      rad_nxt  = {rad_r[qsf_pkg::RAD_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == qsf_pkg::SQRT_CNT_W'(qsf_pkg::ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: src/qsf_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on qsf_pkg
module qsf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qsf_pkg::NUM_W-1:0]  num,
  input  logic [qsf_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [qsf_pkg::NUM_W-1:0]  quo
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [qsf_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [qsf_pkg::NUM_W-1:0]         num_r, num_nxt;
  logic [qsf_pkg::DEN_W-1:0]         den_r, den_nxt;
  logic [qsf_pkg::DEN_W-1:0]         rem_r, rem_nxt;
  logic [qsf_pkg::DEN_W:0]           rem2, diff;
  logic                              ge;

  always_comb begin
    rem2 = {rem_r, num_r[qsf_pkg::NUM_W-1]};
    ge   = rem2 >= {1'b0, den_r};
    diff = rem2 - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // quotient bits fill the dividend register from the bottom
      rem_nxt = ge ? diff[qsf_pkg::DEN_W-1:0] : rem2[qsf_pkg::DEN_W-1:0];
      num_nxt = {num_r[qsf_pkg::NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == qsf_pkg::DIV_CNT_W'(qsf_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// File: src/quaternion_smoothing_filter.sv
// Quaternion smoothing filter (exponential smoothing with renormalisation), Q2.14 in and out.
// One item is worked on at a time. A first sample or a restart goes from idle straight to the
// done state and from there back to idle. Otherwise the dot product, distance and threshold
// squares go through one shared bit-serial multiplier that takes 17 steps a product between a
// start and a hand-back; a held sample leaves after nine products. A full update adds the motion
// test, 12 more products for the blend and its magnitude, a square root and four divisions. The
// result waits in an output register, and a new transfer is taken as soon as the sequencer is
// back in idle.
// Configuration writes are taken in any cycle and must only be issued while the block is idle.
// depends on qsf_pkg, qsf_in_if, qsf_out_if, qsf_cfg_if, qsf_mul, qsf_sqrt, qsf_div
module quaternion_smoothing_filter (
  input  logic      clk,
  input  logic      rst_n,
  qsf_in_if.sink    in_if,
  qsf_out_if.source out_if,
  qsf_cfg_if.sink   cfg_if
);

  qsf_pkg::state_t  state_r, state_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             primed_r, primed_nxt;
  qsf_pkg::comp_t   c_r [4], c_nxt [4];
  qsf_pkg::comp_t   prev_r [4], prev_nxt [4];
  qsf_pkg::comp_t   sm_r [4], sm_nxt [4];
  qsf_pkg::word_t   mag_r [4], mag_nxt [4];
  logic [3:0]       neg_r, neg_nxt;
  qsf_pkg::prod_t   acc_r, acc_nxt;
  logic [qsf_pkg::MAG2_W-1:0] mag2_r, mag2_nxt;
  qsf_pkg::word_t   w_r, w_nxt;
  logic [qsf_pkg::ROOT_W-1:0] r_r, r_nxt;
  logic             out_valid_r, out_valid_nxt;
  qsf_pkg::comp_t   o_r [4], o_nxt [4];
  qsf_pkg::word_t   blend_r, fast_r, dead_r, motion_r;

  logic             in_acc, out_acc;
  logic             mul_start, mul_done;
  qsf_pkg::mul_in_t mul_a, mul_b;
  qsf_pkg::prod_t   mul_p;
  logic             sqrt_start, sqrt_done;
  logic [qsf_pkg::ROOT_W-1:0] sqrt_root;
  logic             div_start, div_done;
  logic [qsf_pkg::NUM_W-1:0]  div_num, div_quo;
  logic signed [qsf_pkg::COMP_W:0] delta;
  logic [16:0]      w_cmp;
  qsf_pkg::prod_t   abs_b, rnd;
  qsf_pkg::word_t   q_sat;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qsf_pkg::S_IDLE:   if (in_acc) begin
        state_nxt = (in_if.restart || !primed_r) ? qsf_pkg::S_DONE : qsf_pkg::S_DOT;
      end
      qsf_pkg::S_DOT:    state_nxt = qsf_pkg::S_DOT_W;
      qsf_pkg::S_DOT_W:  if (mul_done) begin
        state_nxt = (k_r == 2'd3) ? qsf_pkg::S_FLIP : qsf_pkg::S_DOT;
      end
      qsf_pkg::S_FLIP:   state_nxt = qsf_pkg::S_DIST;
      qsf_pkg::S_DIST:   state_nxt = qsf_pkg::S_DIST_W;
      qsf_pkg::S_DIST_W: if (mul_done) begin
        state_nxt = (k_r == 2'd3) ? qsf_pkg::S_DB : qsf_pkg::S_DIST;
      end
      qsf_pkg::S_DB:     state_nxt = qsf_pkg::S_DB_W;
      qsf_pkg::S_DB_W:   if (mul_done) begin
        state_nxt = (acc_r < mul_p) ? qsf_pkg::S_DONE : qsf_pkg::S_ML;
      end
      qsf_pkg::S_ML:     state_nxt = qsf_pkg::S_ML_W;
      qsf_pkg::S_ML_W:   if (mul_done) state_nxt = qsf_pkg::S_BLA;
      qsf_pkg::S_BLA:    state_nxt = qsf_pkg::S_BLA_W;
      qsf_pkg::S_BLA_W:  if (mul_done) state_nxt = qsf_pkg::S_BLB;
      qsf_pkg::S_BLB:    state_nxt = qsf_pkg::S_BLB_W;
      qsf_pkg::S_BLB_W:  if (mul_done) state_nxt = qsf_pkg::S_RND;
      qsf_pkg::S_RND:    state_nxt = qsf_pkg::S_MAG;
      qsf_pkg::S_MAG:    state_nxt = qsf_pkg::S_MAG_W;
      qsf_pkg::S_MAG_W:  if (mul_done) begin
        state_nxt = (k_r == 2'd3) ? qsf_pkg::S_RANGE : qsf_pkg::S_BLA;
      end
      qsf_pkg::S_RANGE:  begin
        state_nxt = (mag2_r < qsf_pkg::MAG2_MIN || mag2_r > qsf_pkg::MAG2_MAX)
                    ? qsf_pkg::S_DONE : qsf_pkg::S_SQRT;
      end
      qsf_pkg::S_SQRT:   state_nxt = qsf_pkg::S_SQRT_W;
      qsf_pkg::S_SQRT_W: if (sqrt_done) state_nxt = qsf_pkg::S_DIV;
      qsf_pkg::S_DIV:    state_nxt = qsf_pkg::S_DIV_W;
      qsf_pkg::S_DIV_W:  if (div_done) begin
        state_nxt = (k_r == 2'd3) ? qsf_pkg::S_DONE : qsf_pkg::S_DIV;
      end
      qsf_pkg::S_DONE:   if (!out_valid_r || out_if.ready) state_nxt = qsf_pkg::S_IDLE;
      default:           state_nxt = qsf_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    k_nxt         = k_r;
    primed_nxt    = primed_r;
    c_nxt         = c_r;
    prev_nxt      = prev_r;
    sm_nxt        = sm_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    mag2_nxt      = mag2_r;
    w_nxt         = w_r;
    r_nxt         = r_r;
    o_nxt         = o_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    mul_start     = 1'b0;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    delta = (qsf_pkg::COMP_W+1)'(c_r[k_r]) - (qsf_pkg::COMP_W+1)'(prev_r[k_r]);
    w_cmp = 17'h10000 - {1'b0, w_r};
    abs_b = acc_r[qsf_pkg::PROD_W-1] ? -acc_r : acc_r;
    rnd   = abs_b + qsf_pkg::PROD_W'(32768);
    q_sat = (div_quo > qsf_pkg::NUM_W'(qsf_pkg::Q_MAX)) ? qsf_pkg::word_t'(qsf_pkg::Q_MAX)
                                                       : div_quo[qsf_pkg::COMP_W-1:0];
    div_num = {mag_r[k_r], qsf_pkg::NORM_SHIFT'(0)} + qsf_pkg::NUM_W'(r_r >> 1);

    unique case (state_r)
      qsf_pkg::S_IDLE: if (in_acc) begin
        c_nxt[0] = in_if.in_w;
        c_nxt[1] = in_if.in_x;
        c_nxt[2] = in_if.in_y;
        c_nxt[3] = in_if.in_z;
        k_nxt    = '0;
        acc_nxt  = '0;
        if (in_if.restart || !primed_r) begin
          sm_nxt     = c_nxt;
          prev_nxt   = c_nxt;
          primed_nxt = 1'b1;
        end
      end
      qsf_pkg::S_DOT: begin
        mul_start = 1'b1;
        mul_a     = qsf_pkg::mul_in_t'(prev_r[k_r]);
        mul_b     = qsf_pkg::mul_in_t'(c_r[k_r]);
      end
      qsf_pkg::S_DOT_W: if (mul_done) begin
        acc_nxt = acc_r + mul_p;
        k_nxt   = k_r + 1'b1;
      end
      qsf_pkg::S_FLIP: begin
        // sign flip onto the same hemisphere; the most negative value saturates
        if (acc_r[qsf_pkg::PROD_W-1]) begin
          for (int i = 0; i < 4; i++) begin
            c_nxt[i] = (c_r[i] == qsf_pkg::Q_MIN) ? qsf_pkg::Q_MAX : -c_r[i];
          end
        end
        acc_nxt = '0;
      end
      qsf_pkg::S_DIST: begin
        mul_start = 1'b1;
        mul_a     = qsf_pkg::mul_in_t'(delta);
        mul_b     = qsf_pkg::mul_in_t'(delta);
      end
      qsf_pkg::S_DIST_W: if (mul_done) begin
        acc_nxt = acc_r + mul_p;
        k_nxt   = k_r + 1'b1;
      end
      qsf_pkg::S_DB: begin
        mul_start = 1'b1;
        mul_a     = {2'b00, dead_r};
        mul_b     = {2'b00, dead_r};
      end
      qsf_pkg::S_DB_W: ;
      qsf_pkg::S_ML: begin
        mul_start = 1'b1;
        mul_a     = {2'b00, motion_r};
        mul_b     = {2'b00, motion_r};
      end
      qsf_pkg::S_ML_W: if (mul_done) begin
        w_nxt    = (acc_r > mul_p) ? fast_r : blend_r;
        mag2_nxt = '0;
      end
      qsf_pkg::S_BLA: begin
        mul_start = 1'b1;
        mul_a     = {2'b00, w_r};
        mul_b     = qsf_pkg::mul_in_t'(c_r[k_r]);
      end
      qsf_pkg::S_BLA_W: if (mul_done) acc_nxt = mul_p;
      qsf_pkg::S_BLB: begin
        mul_start = 1'b1;
        mul_a     = {1'b0, w_cmp};
        mul_b     = qsf_pkg::mul_in_t'(sm_r[k_r]);
      end
      qsf_pkg::S_BLB_W: if (mul_done) acc_nxt = acc_r + mul_p;
      qsf_pkg::S_RND: begin
        // round to Q2.14, half away from zero
        neg_nxt[k_r] = acc_r[qsf_pkg::PROD_W-1];
        mag_nxt[k_r] = rnd[31:16];
      end
      qsf_pkg::S_MAG: begin
        mul_start = 1'b1;
        mul_a     = {2'b00, mag_r[k_r]};
        mul_b     = {2'b00, mag_r[k_r]};
      end
      qsf_pkg::S_MAG_W: if (mul_done) begin
        mag2_nxt = mag2_r + mul_p[qsf_pkg::MAG2_W-1:0];
        k_nxt    = k_r + 1'b1;
      end
      qsf_pkg::S_RANGE: begin
        if (mag2_r < qsf_pkg::MAG2_MIN || mag2_r > qsf_pkg::MAG2_MAX) begin
          // degenerate blend falls back to the identity
          sm_nxt[0] = qsf_pkg::Q_ONE;
          sm_nxt[1] = '0;
          sm_nxt[2] = '0;
          sm_nxt[3] = '0;
          prev_nxt  = c_r;
        end
      end
      qsf_pkg::S_SQRT: sqrt_start = 1'b1;
      qsf_pkg::S_SQRT_W: if (sqrt_done) r_nxt = sqrt_root;
      qsf_pkg::S_DIV: div_start = 1'b1;
      qsf_pkg::S_DIV_W: if (div_done) begin
        sm_nxt[k_r] = neg_r[k_r] ? -qsf_pkg::comp_t'(q_sat) : qsf_pkg::comp_t'(q_sat);
        k_nxt       = k_r + 1'b1;
        if (k_r == 2'd3) prev_nxt = c_r;
      end
      qsf_pkg::S_DONE: if (!out_valid_r || out_if.ready) begin
        o_nxt         = sm_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qsf_pkg::S_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      blend_r     <= qsf_pkg::BLEND_RST;
      fast_r      <= qsf_pkg::FAST_RST;
      dead_r      <= qsf_pkg::DEAD_RST;
      motion_r    <= qsf_pkg::MOTION_RST;
      for (int i = 0; i < 4; i++) begin
        sm_r[i]   <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      sm_r        <= sm_nxt;
      prev_r      <= prev_nxt;
      if (cfg_if.valid) begin
        unique case (qsf_pkg::cfg_reg_t'(cfg_if.index))
          qsf_pkg::REG_BLEND:  blend_r  <= cfg_if.data;
          qsf_pkg::REG_FAST:   fast_r   <= cfg_if.data;
          qsf_pkg::REG_DEAD:   dead_r   <= cfg_if.data;
          qsf_pkg::REG_MOTION: motion_r <= cfg_if.data;
          default: ;
        endcase
      end
    end
    k_r    <= k_nxt;
    c_r    <= c_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    mag2_r <= mag2_nxt;
    w_r    <= w_nxt;
    r_r    <= r_nxt;
    o_r    <= o_nxt;
  end

  assign in_if.ready  = (state_r == qsf_pkg::S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.out_w = o_r[0];
  assign out_if.out_x = o_r[1];
  assign out_if.out_y = o_r[2];
  assign out_if.out_z = o_r[3];

  qsf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  qsf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   ({1'b0, mag2_r, 16'd0}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  qsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (r_r),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
